>>> design/nprm_pkg.sv
// shared types, constants and palette table for the nearest palette color match core
package nprm_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int IDX_W       = 4;
  localparam int CH_W        = 8;
  localparam int SQ_W        = 2 * CH_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int ROOT_W      = SUM_W / 2;
  localparam int REM_W       = ROOT_W + 1;
  localparam int SQRT_STEPS  = ROOT_W;

  // entry that holds the best match before the scan starts
  localparam logic [IDX_W-1:0] START_IDX = IDX_W'(1);
  // entry that repeats entry 0 and can never win
  localparam logic [IDX_W-1:0] DUP_IDX   = IDX_W'(8);

  typedef logic [ROOT_W-1:0] root_t;

  typedef struct packed {
    logic [SUM_W-1:0] rad;
    logic [REM_W-1:0] rem;
    root_t            root;
  } sqrt_lane_t;

  typedef struct packed {
    sqrt_lane_t [NUM_ENTRIES-1:0] lane;
  } sqrt_word_t;

  typedef struct packed {
    root_t [NUM_ENTRIES-1:0] root;
    logic  [IDX_W-1:0]       best_idx;
    root_t                   best_root;
  } cmp_word_t;

  // palette as {red, green, blue}
  function automatic logic [3*CH_W-1:0] pal_color(input logic [IDX_W-1:0] idx);
    logic [3*CH_W-1:0] c;
    case (idx)
      4'd0:    c = {8'd0,   8'd0,   8'd0};
      4'd1:    c = {8'd0,   8'd0,   8'd178};
      4'd2:    c = {8'd0,   8'd178, 8'd0};
      4'd3:    c = {8'd0,   8'd178, 8'd178};
      4'd4:    c = {8'd178, 8'd0,   8'd0};
      4'd5:    c = {8'd255, 8'd127, 8'd255};
      4'd6:    c = {8'd204, 8'd153, 8'd102};
      4'd7:    c = {8'd127, 8'd127, 8'd127};
      4'd8:    c = {8'd0,   8'd0,   8'd0};
      4'd9:    c = {8'd102, 8'd102, 8'd255};
      4'd10:   c = {8'd102, 8'd255, 8'd102};
      4'd11:   c = {8'd0,   8'd255, 8'd100};
      4'd12:   c = {8'd255, 8'd102, 8'd102};
      4'd13:   c = {8'd255, 8'd204, 8'd255};
      4'd14:   c = {8'd255, 8'd255, 8'd0};
      4'd15:   c = {8'd255, 8'd255, 8'd255};
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d * d);
  endfunction

  // squared euclidean distance from a color to one palette entry
  function automatic logic [SUM_W-1:0] entry_sum(input logic [IDX_W-1:0] idx,
                                                 input logic [CH_W-1:0]  r,
                                                 input logic [CH_W-1:0]  g,
                                                 input logic [CH_W-1:0]  b);
    logic [3*CH_W-1:0] c;
    c = pal_color(idx);
    return SUM_W'(sq_diff(c[3*CH_W-1:2*CH_W], r))
         + SUM_W'(sq_diff(c[2*CH_W-1:CH_W], g))
         + SUM_W'(sq_diff(c[CH_W-1:0], b));
  endfunction

endpackage

>>> design/nprm_if.sv
// valid/ready channel interfaces for color words and palette index words
interface nprm_in_if;
  logic                      valid;
  logic                      ready;
  logic [nprm_pkg::CH_W-1:0] red;
  logic [nprm_pkg::CH_W-1:0] green;
  logic [nprm_pkg::CH_W-1:0] blue;

  modport source(output valid, red, green, blue, input ready);
  modport sink(input valid, red, green, blue, output ready);
endinterface

interface nprm_out_if;
  logic                       valid;
  logic                       ready;
  logic [nprm_pkg::IDX_W-1:0] palette_index;

  modport source(output valid, palette_index, input ready);
  modport sink(input valid, palette_index, output ready);
endinterface

>>> design/nprm_sqrt_cell.sv
// one digit step of the floor square root for all palette lanes, registered
module nprm_sqrt_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  nprm_pkg::sqrt_word_t up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output nprm_pkg::sqrt_word_t dn_data
);

  logic                 valid_r;
  nprm_pkg::sqrt_word_t data_r;
  nprm_pkg::sqrt_word_t data_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // bring down the next two radicand bits, try root*4+1
  always_comb begin
    logic [nprm_pkg::REM_W+1:0] cat;
    logic [nprm_pkg::REM_W+1:0] trial;
    for (int i = 0; i < nprm_pkg::NUM_ENTRIES; i++) begin
      cat   = {up_data.lane[i].rem, up_data.lane[i].rad[nprm_pkg::SUM_W-1 -: 2]};
      trial = (nprm_pkg::REM_W + 2)'({up_data.lane[i].root, 2'b01});
      data_nxt.lane[i].rad = {up_data.lane[i].rad[nprm_pkg::SUM_W-3:0], 2'b00};
      if (cat >= trial) begin
        data_nxt.lane[i].rem  = nprm_pkg::REM_W'(cat - trial);
        data_nxt.lane[i].root = {up_data.lane[i].root[nprm_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        data_nxt.lane[i].rem  = nprm_pkg::REM_W'(cat);
        data_nxt.lane[i].root = {up_data.lane[i].root[nprm_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> design/nprm_cmp_cell.sv
// one palette entry of the best-match scan, registered
module nprm_cmp_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [nprm_pkg::IDX_W-1:0]    cell_idx,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  nprm_pkg::cmp_word_t           up_data,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output nprm_pkg::cmp_word_t           dn_data
);

  logic                valid_r;
  nprm_pkg::cmp_word_t data_r;
  nprm_pkg::cmp_word_t data_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // strictly smaller wins, ties keep the earlier winner
  always_comb begin
    data_nxt = up_data;
    if (up_data.root[cell_idx] < up_data.best_root) begin
      data_nxt.best_idx  = cell_idx;
      data_nxt.best_root = up_data.root[cell_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_best_matches_root: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> data_r.root[data_r.best_idx] == data_r.best_root)
    else $error("best root does not match root of best index");

  a_best_not_worse: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> data_r.best_root <= data_r.root[cell_idx])
    else $error("best root larger than root of scanned entry");

  a_dup_never_best: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> data_r.best_idx != nprm_pkg::DUP_IDX)
    else $error("duplicate entry became best match");
`endif

endmodule

>>> design/nearest_palette_color_match_core.sv
// nearest palette color match core: squared distance, square root cells, scan cells
// a color word leaves as an index word after passing through every stage in order
//   (1 distance stage, 9 square root digit cells, 16 scan cells, one per palette entry)
// throughput: one color word per cycle, stalls only while every stage holds a word
// ready runs back from each stage, so bubbles are squeezed out under backpressure
// reset: synchronous active low, empties every stage; no other state is kept
module nearest_palette_color_match_core (
  input  logic              clk,
  input  logic              rst_n,
  nprm_in_if.sink           in_ch,
  nprm_out_if.source        out_ch
);

  // distance stage: squared distance to every palette entry
  logic                 sum_valid_r;
  nprm_pkg::sqrt_word_t sum_data_r;
  nprm_pkg::sqrt_word_t sum_data_nxt;
  logic                 sum_ready;

  // square root chain, element 0 fed by the distance stage
  logic                 sq_valid [nprm_pkg::SQRT_STEPS+1];
  logic                 sq_ready [nprm_pkg::SQRT_STEPS+1];
  nprm_pkg::sqrt_word_t sq_data  [nprm_pkg::SQRT_STEPS+1];

  // scan chain, element 0 fed by the roots
  logic                 cm_valid [nprm_pkg::NUM_ENTRIES+1];
  logic                 cm_ready [nprm_pkg::NUM_ENTRIES+1];
  nprm_pkg::cmp_word_t  cm_data  [nprm_pkg::NUM_ENTRIES+1];

  assign sum_ready   = !sum_valid_r || sq_ready[0];
  assign in_ch.ready = sum_ready;

  // fresh root lane: whole radicand, zero remainder, zero root
  always_comb begin
    for (int i = 0; i < nprm_pkg::NUM_ENTRIES; i++) begin
      sum_data_nxt.lane[i].rad  = nprm_pkg::entry_sum(nprm_pkg::IDX_W'(i),
                                                      in_ch.red, in_ch.green, in_ch.blue);
      sum_data_nxt.lane[i].rem  = '0;
      sum_data_nxt.lane[i].root = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
    end else if (sum_ready) begin
      sum_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready && in_ch.valid) begin
      sum_data_r <= sum_data_nxt;
    end
  end

  assign sq_valid[0] = sum_valid_r;
  assign sq_data[0]  = sum_data_r;

  // one root digit per cell, most significant first
  for (genvar s = 0; s < nprm_pkg::SQRT_STEPS; s++) begin : g_sqrt
    nprm_sqrt_cell u_sqrt_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sq_valid[s]),
      .up_ready (sq_ready[s]),
      .up_data  (sq_data[s]),
      .dn_valid (sq_valid[s+1]),
      .dn_ready (sq_ready[s+1]),
      .dn_data  (sq_data[s+1])
    );
  end

  // hand roots to the scan, starting winner is entry 1 at its own distance
  assign cm_valid[0]                = sq_valid[nprm_pkg::SQRT_STEPS];
  assign sq_ready[nprm_pkg::SQRT_STEPS] = cm_ready[0];

  always_comb begin
    for (int i = 0; i < nprm_pkg::NUM_ENTRIES; i++) begin
      cm_data[0].root[i] = sq_data[nprm_pkg::SQRT_STEPS].lane[i].root;
    end
    cm_data[0].best_idx  = nprm_pkg::START_IDX;
    cm_data[0].best_root = sq_data[nprm_pkg::SQRT_STEPS].lane[nprm_pkg::START_IDX].root;
  end

  // scan cells in palette order, the last one is the output register
  for (genvar e = 0; e < nprm_pkg::NUM_ENTRIES; e++) begin : g_scan
    nprm_cmp_cell u_cmp_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (nprm_pkg::IDX_W'(e)),
      .up_valid (cm_valid[e]),
      .up_ready (cm_ready[e]),
      .up_data  (cm_data[e]),
      .dn_valid (cm_valid[e+1]),
      .dn_ready (cm_ready[e+1]),
      .dn_data  (cm_data[e+1])
    );
  end

  assign out_ch.valid                  = cm_valid[nprm_pkg::NUM_ENTRIES];
  assign out_ch.palette_index          = cm_data[nprm_pkg::NUM_ENTRIES].best_idx;
  assign cm_ready[nprm_pkg::NUM_ENTRIES] = out_ch.ready;

`ifndef NO_ASSERTIONS
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && !sum_valid_r)
    else $error("pipeline not empty after reset");

  a_sum_holds: assert property (@(posedge clk) disable iff (!rst_n)
    sum_valid_r && !sq_ready[0] |=> sum_valid_r && $stable(sum_data_r))
    else $error("distance word lost while stalled");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> sum_valid_r && sq_valid[0] && !sq_ready[0])
    else $error("input stalled with room in the distance stage");
`endif

endmodule
